// ----- sv/keyframe_matrix_interpolator_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the keyframe matrix interpolator
// ---------------------------------------------------------------------------
`ifndef KEYFRAME_MATRIX_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_MATRIX_INTERPOLATOR_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define KMI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define KMI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/kmi_pkg.sv -----
// ---------------------------------------------------------------------------
// kmi_pkg
// Types and constants shared by the keyframe matrix interpolator.
// ---------------------------------------------------------------------------
package kmi_pkg;

  localparam int MAX_KEYS = 256;
  localparam int KEY_W    = $clog2(MAX_KEYS);
  localparam int ELEMS    = 16;
  localparam int ELEM_W   = 4;
  localparam int CNT_W    = 9;

  localparam logic [1:0] OP_WR_ELEM = 2'd0;
  localparam logic [1:0] OP_WR_TICK = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         key_index;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic [31:0]        time_value;
  } kmi_in_t;

  typedef struct packed {
    logic [3:0]         element_index_out;
    logic signed [31:0] element_result;
    logic [7:0]         segment;
    logic               saturated;
    logic               last;
  } kmi_out_t;

endpackage

// ----- sv/keyframe_matrix_interpolator.sv -----
// ---------------------------------------------------------------------------
// keyframe_matrix_interpolator
// Linear interpolation between 4x4 Q16.16 animation keys.
// ---------------------------------------------------------------------------
// Write items (element or tick) are taken in the idle state and busy never
// rises for them. A query holds busy while it runs: it fetches and tests the
// remembered segment, then reads and compares the next tick for each key
// tested by the search, with one more step when it runs past the last key,
// fetches both ticks and sets up the divide, runs a 48-step restoring
// divider for offset/delta (one quotient bit per cycle) and signs and clamps
// the fraction (both skipped when the two ticks are equal), then for each of
// the 16 elements reads k1, reads k2, forms two 32x33-bit products, and
// rounds and saturates. How long a query stays busy depends on how many keys
// the search tests. out_valid strobes each result for one cycle; the
// receiver cannot stall, so results leave as they are made.
// The key count register is taken only while the block is idle. Memories need
// no clear: unwritten keys are never read by a legal user.
// ---------------------------------------------------------------------------
`include "keyframe_matrix_interpolator_macros.svh"

module keyframe_matrix_interpolator
  import kmi_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  kmi_in_t       in_item,
  output logic          out_valid,
  output kmi_out_t      out_item,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRD   = 4'd1;  // read tick[idx]
  localparam logic [3:0] S_SCHK0 = 4'd2;  // restart test
  localparam logic [3:0] S_SNRD  = 4'd3;  // read tick[idx+1]
  localparam logic [3:0] S_SNCHK = 4'd4;  // advance test
  localparam logic [3:0] S_T1RD  = 4'd5;  // read tick[first]
  localparam logic [3:0] S_T2RD  = 4'd6;  // read tick[first+1]
  localparam logic [3:0] S_DSET  = 4'd7;  // both ticks at hand
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_FIX   = 4'd9;
  localparam logic [3:0] S_ERD   = 4'd10; // read k1
  localparam logic [3:0] S_ERD2  = 4'd11; // k1 back, read k2
  localparam logic [3:0] S_MUL   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state_r, state_nxt;

  // tick memory
  logic [31:0] tick_mem [MAX_KEYS];
  logic [KEY_W-1:0] tick_ra;
  logic [31:0] tick_rd_r;
  // matrix memory
  logic [31:0] mat_mem [MAX_KEYS*ELEMS];
  logic [KEY_W+ELEM_W-1:0] mat_ra;
  logic [31:0] mat_rd_r;

  logic [CNT_W-1:0] key_count_r;
  logic [KEY_W-1:0] cached_r;
  logic [KEY_W:0]   idx_r, idx_nxt;
  logic [KEY_W-1:0] first_r, first_nxt;
  logic [31:0] t_r, t1_r, t1_nxt;
  logic [CNT_W-1:0] n_act;
  logic [KEY_W:0]   last_idx;

  // divider
  logic [47:0] dvd_r;       // |offset|<<16
  logic [31:0] dvs_r;       // |delta|
  logic [47:0] quo_r;
  logic [32:0] rem_r;
  logic [5:0]  dcnt_r;
  logic        neg_r;
  logic signed [31:0] f_r;  // clamped fraction, fits in 32 bits

  logic [3:0]  e_r;
  logic signed [31:0] k1_r;
  logic signed [63:0] p1_r, p2_r;
  logic signed [64:0] sum_w, rnd_w;
  logic signed [48:0] r_w;
  logic        out_valid_r;
  kmi_out_t    out_r;

  assign cfg_ready = !busy;
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    n_act = key_count_r;
    if (key_count_r < CNT_W'(2)) n_act = CNT_W'(2);
    if (key_count_r > CNT_W'(MAX_KEYS)) n_act = CNT_W'(MAX_KEYS);
  end
  assign last_idx = (KEY_W+1)'(n_act - CNT_W'(1));

  logic accept;
  assign accept = start && !busy;

  // memory writes and reads
  always_ff @(posedge clk) begin
    if (accept && in_item.opcode == OP_WR_TICK)
      tick_mem[in_item.key_index[KEY_W-1:0]] <= in_item.time_value;
    if (accept && in_item.opcode == OP_WR_ELEM)
      mat_mem[{in_item.key_index[KEY_W-1:0], in_item.element_index}] <=
        in_item.element_value;
    tick_rd_r <= tick_mem[tick_ra];
    mat_rd_r  <= mat_mem[mat_ra];
  end

  always_comb begin
    tick_ra = cached_r;
    case (state_r)
      S_SNRD:  tick_ra = idx_r[KEY_W-1:0] + KEY_W'(1);
      S_T1RD:  tick_ra = first_r;
      S_T2RD:  tick_ra = first_r + KEY_W'(1);
      default: tick_ra = idx_r[KEY_W-1:0];
    endcase
  end

  always_comb begin
    mat_ra = {first_r, e_r};
    if (state_r == S_ERD2) mat_ra = {first_r + KEY_W'(1), e_r};
  end

  // in S_DSET t1_r holds tick[first] and tick_rd_r holds tick[first+1]
  logic [31:0] off_w, del_w;
  assign off_w = t_r - t1_r;
  assign del_w = tick_rd_r - t1_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    first_nxt = first_r;
    t1_nxt    = t1_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_item.opcode == OP_QUERY) begin
          state_nxt = S_SRD;
          idx_nxt   = {1'b0, cached_r};
        end
      end
      S_SRD: state_nxt = S_SCHK0;
      S_SCHK0: begin
        if (idx_r >= last_idx || t_r < tick_rd_r) idx_nxt = '0;
        state_nxt = S_SNRD;
      end
      S_SNRD: begin
        if (idx_r >= last_idx) begin
          first_nxt = KEY_W'(last_idx - (KEY_W+1)'(1));
          state_nxt = S_T1RD;
        end else begin
          state_nxt = S_SNCHK;
        end
      end
      S_SNCHK: begin
        if (t_r < tick_rd_r) begin
          first_nxt = idx_r[KEY_W-1:0];
          state_nxt = S_T1RD;
        end else begin
          idx_nxt   = idx_r + (KEY_W+1)'(1);
          state_nxt = S_SNRD;
        end
      end
      S_T1RD: state_nxt = S_T2RD;
      S_T2RD: begin
        t1_nxt    = tick_rd_r;
        state_nxt = S_DSET;
      end
      S_DSET: state_nxt = (del_w == 32'd0) ? S_ERD : S_DIV;
      S_DIV:  if (dcnt_r == 6'd0) state_nxt = S_FIX;
      S_FIX:  state_nxt = S_ERD;
      S_ERD:  state_nxt = S_ERD2;
      S_ERD2: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_OUT;
      S_OUT:  state_nxt = (e_r == 4'd15) ? S_IDLE : S_ERD;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [32:0] trial;
  assign trial = {rem_r[31:0], dvd_r[47]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_count_r <= CNT_W'(2);
      cached_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) key_count_r <= cfg_data;
      if (state_r == S_SNRD && idx_r >= last_idx) cached_r <= idx_r[KEY_W-1:0];
      if (state_r == S_SNCHK && t_r < tick_rd_r) cached_r <= idx_r[KEY_W-1:0];
      if (state_r == S_OUT) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    first_r <= first_nxt;
    t1_r    <= t1_nxt;
    if (accept) t_r <= in_item.time_value;
    case (state_r)
      S_DSET: begin
        dvd_r  <= {(off_w[31] ? -off_w : off_w), 16'd0};
        dvs_r  <= del_w[31] ? -del_w : del_w;
        neg_r  <= off_w[31] ^ del_w[31];
        rem_r  <= '0;
        quo_r  <= '0;
        dcnt_r <= 6'd47;
        e_r    <= '0;
        f_r    <= '0;
      end
      S_DIV: begin
        dcnt_r <= dcnt_r - 6'd1;
        dvd_r  <= {dvd_r[46:0], 1'b0};
        if (!trial[32]) begin
          rem_r <= trial;
          quo_r <= {quo_r[46:0], 1'b1};
        end else begin
          rem_r <= {rem_r[31:0], dvd_r[47]};
          quo_r <= {quo_r[46:0], 1'b0};
        end
      end
      S_FIX: begin
        if (quo_r > 48'd1073741824)
          f_r <= neg_r ? -32'sd1073741824 : 32'sd1073741824;
        else
          f_r <= neg_r ? -$signed(quo_r[31:0]) : $signed(quo_r[31:0]);
      end
      S_ERD2: ;
      S_MUL: begin
        p1_r <= 64'($signed(k1_r)) * 64'(33'sd65536 - 33'($signed(f_r)));
        p2_r <= 64'($signed(mat_rd_r)) * 64'($signed(f_r));
      end
      S_OUT: e_r <= e_r + 4'd1;
      default: ;
    endcase
    if (state_r == S_ERD2) k1_r <= $signed(mat_rd_r);
  end

  // k1 arrives in S_ERD2 (read issued in S_ERD); k2 arrives in S_MUL
  assign sum_w = 65'(p1_r) + 65'(p2_r);
  assign rnd_w = sum_w + 65'sd32768;
  assign r_w   = 49'(rnd_w >>> 16);

  always_ff @(posedge clk) begin
    if (state_r == S_OUT) begin
      out_r.element_index_out <= e_r;
      out_r.segment           <= 8'(first_r);
      out_r.last              <= (e_r == 4'd15);
      if (r_w > 49'sd2147483647) begin
        out_r.element_result <= 32'sh7FFF_FFFF;
        out_r.saturated      <= 1'b1;
      end else if (r_w < -49'sd2147483648) begin
        out_r.element_result <= 32'sh8000_0000;
        out_r.saturated      <= 1'b1;
      end else begin
        out_r.element_result <= r_w[31:0];
        out_r.saturated      <= 1'b0;
      end
    end
  end

  `KMI_ASSERT_NEXT(a_busy_after_query, accept && in_item.opcode == OP_QUERY, busy,
    "query accepted but block not busy")
  `KMI_ASSERT_IMP(a_no_out_idle_write, out_valid, $past(state_r) == S_OUT,
    "result strobe without element stage")
  `KMI_ASSERT_IMP(a_cache_in_range, state_r == S_T1RD, idx_r <= last_idx,
    "search index past last key")

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyframe matrix interpolator: loads key tables,
// runs directed and random queries and compares every emitted element
// against a behavioral interpolation computed alongside the stimulus.
// ---------------------------------------------------------------------------
module tb_top
  import kmi_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 200;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  kmi_in_t          in_item = '0;
  logic             out_valid;
  kmi_out_t         out_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  always #10 clk = ~clk;

  keyframe_matrix_interpolator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the block's state. Only written keys are ever queried.
  logic [31:0] tick_mem [MAX_KEYS];
  logic [31:0] mat_mem [MAX_KEYS*ELEMS];
  logic [7:0]  seg_cache;
  int unsigned num_keys;

  kmi_out_t    pending_elems[$];
  int          error_count = 0;
  int          idle_cycles = 0;

  task automatic report_mismatch(input string what);
    $display("%0t MISMATCH %s", $time, what);
    error_count++;
  endtask

  // Interpolate one query time and queue the 16 expected elements.
  task automatic interpolate_query(input logic [31:0] t);
    int unsigned n, last_idx, idx, first;
    longint frac, k1, k2, sum, r;
    int signed delta, offset;
    kmi_out_t exp_elem;
    n = num_keys < 2 ? 2 : (num_keys > MAX_KEYS ? MAX_KEYS : num_keys);
    last_idx = n - 1;
    idx = seg_cache;
    frac = 0;
    if (idx >= last_idx || t < tick_mem[idx]) idx = 0;
    first = last_idx - 1;
    for (; idx < last_idx; idx++) begin
      if (t < tick_mem[idx+1]) begin
        first = idx;
        break;
      end
    end
    seg_cache = idx[7:0];
    delta = signed'(tick_mem[first+1] - tick_mem[first]);
    offset = signed'(t - tick_mem[first]);
    if (delta != 0) begin
      frac = (longint'(offset) * 65536) / longint'(delta);
      if (frac > 64'sd1073741824) frac = 64'sd1073741824;
      if (frac < -64'sd1073741824) frac = -64'sd1073741824;
    end
    for (int e = 0; e < ELEMS; e++) begin
      k1 = longint'(signed'(mat_mem[first*ELEMS + e]));
      k2 = longint'(signed'(mat_mem[(first+1)*ELEMS + e]));
      sum = k1 * (65536 - frac) + k2 * frac + 32768;
      r = sum >>> 16;   // arithmetic shift floors toward minus infinity
      exp_elem.saturated = 1'b0;
      if (r > 64'sd2147483647) begin
        r = 64'sd2147483647;
        exp_elem.saturated = 1'b1;
      end else if (r < -64'sd2147483648) begin
        r = -64'sd2147483648;
        exp_elem.saturated = 1'b1;
      end
      exp_elem.element_index_out = e[3:0];
      exp_elem.element_result = r[31:0];
      exp_elem.segment = first[7:0];
      exp_elem.last = (e == ELEMS-1);
      pending_elems.insert(pending_elems.size(), exp_elem);
    end
  endtask

  task automatic model_item(input kmi_in_t it);
    case (it.opcode)
      OP_WR_ELEM: mat_mem[it.key_index*ELEMS + it.element_index] = it.element_value;
      OP_WR_TICK: tick_mem[it.key_index] = it.time_value;
      OP_QUERY:   interpolate_query(it.time_value);
      default: ;
    endcase
  endtask

  // Result checker: the receiver cannot stall, so every strobe is taken.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      kmi_out_t exp_elem;
      if (pending_elems.size() == 0) begin
        report_mismatch("unexpected element");
      end else begin
        exp_elem = pending_elems.pop_front();
        if (out_item.element_index_out !== exp_elem.element_index_out)
          report_mismatch($sformatf("index %0d exp %0d", out_item.element_index_out,
                                    exp_elem.element_index_out));
        if (out_item.element_result !== exp_elem.element_result)
          report_mismatch($sformatf("result %h exp %h", out_item.element_result,
                                    exp_elem.element_result));
        if (out_item.segment !== exp_elem.segment)
          report_mismatch($sformatf("segment %0d exp %0d", out_item.segment,
                                    exp_elem.segment));
        if (out_item.saturated !== exp_elem.saturated)
          report_mismatch("saturated flag");
        if (out_item.last !== exp_elem.last)
          report_mismatch("last flag");
      end
    end
  end

  // Watchdog on cycles with no accepted item, element or register write.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  int burst_left = 0;

  // Issue one item; bursts of back-to-back items, sometimes separated by random gaps.
  // start stays high between items of a burst and drops only for a gap.
  task automatic send_item(input kmi_in_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    model_item(it);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_key_count(input logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    num_keys = value;
  endtask

  function automatic kmi_in_t make_item(input logic [1:0] op, input logic [7:0] key,
                                        input logic [3:0] elem, input logic [31:0] val,
                                        input logic [31:0] t);
    kmi_in_t it;
    it.opcode = op;
    it.key_index = key;
    it.element_index = elem;
    it.element_value = val;
    it.time_value = t;
    return it;
  endfunction

  // Fill keys 0..n-1 with non-decreasing ticks (or random ones) and random matrices.
  // Most values are small so that interpolation does not saturate everything.
  task automatic load_table(input int n, input bit ordered);
    logic [31:0] tick, val;
    tick = $urandom_range(0, 1000);
    for (int k = 0; k < n; k++) begin
      if (ordered) tick = tick + $urandom_range(0, 3) * $urandom_range(1, 5000);
      else tick = $urandom;
      send_item(make_item(OP_WR_TICK, k[7:0], 4'($urandom), $urandom, tick));
      for (int e = 0; e < ELEMS; e++) begin
        val = ($urandom_range(0, 7) == 0) ? $urandom : 32'($signed($urandom_range(0, 1 << 22))
                                                    - (1 << 21));
        send_item(make_item(OP_WR_ELEM, k[7:0], e[3:0], val, $urandom));
      end
    end
  endtask

  // Directed table. Keys 0 and 1 get extreme matrices; the row's exp column
  // is only used where the result is obvious (queries exactly on a key).
  typedef struct {
    kmi_in_t    it;
    bit         has_exp;
    logic [31:0] exp_elem0;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    logic [31:0] t;
    for (int k = 0; k < MAX_KEYS; k++) tick_mem[k] = '0;
    for (int k = 0; k < MAX_KEYS*ELEMS; k++) mat_mem[k] = '0;
    seg_cache = '0;
    num_keys  = 2;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset key count (2 keys).
    dir_rows.insert(dir_rows.size(),
                    '{make_item(OP_WR_TICK, 8'd0, 4'hF, 32'hFFFF_FFFF, 32'd100), 0, 0});
    dir_rows.insert(dir_rows.size(),
                    '{make_item(OP_WR_TICK, 8'd1, 4'h0, 32'h0, 32'd200), 0, 0});
    for (int e = 0; e < ELEMS; e++) begin
      dir_rows.insert(dir_rows.size(), '{make_item(OP_WR_ELEM, 8'd0, e[3:0],
                      e[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, 32'd0), 0, 0});
      dir_rows.insert(dir_rows.size(), '{make_item(OP_WR_ELEM, 8'd1, e[3:0],
                      e[0] ? 32'h7FFF_FFFF : 32'h8000_0000, 32'd0), 0, 0});
    end
    // On key 0: element 0 is exactly key 0's value.
    dir_rows.insert(dir_rows.size(),
                    '{make_item(OP_QUERY, 8'hFF, 4'hF, 32'hFFFF_FFFF, 32'd100), 1,
                      32'h7FFF_FFFF});
    // Midway, before the table, far past it (extrapolation saturates).
    dir_rows.insert(dir_rows.size(),
                    '{make_item(OP_QUERY, 8'd0, 4'd0, 32'd0, 32'd150), 0, 0});
    dir_rows.insert(dir_rows.size(),
                    '{make_item(OP_QUERY, 8'd0, 4'd0, 32'd0, 32'd0), 0, 0});
    dir_rows.insert(dir_rows.size(),
                    '{make_item(OP_QUERY, 8'd0, 4'd0, 32'd0, 32'hFFFF_FFFF), 0, 0});
    // Unused opcode is ignored; write to key 255 is outside the active table.
    dir_rows.insert(dir_rows.size(),
                    '{make_item(2'd3, 8'hAA, 4'h5, 32'h5555_5555, 32'hAAAA_AAAA), 0, 0});
    dir_rows.insert(dir_rows.size(),
                    '{make_item(OP_WR_TICK, 8'hFF, 4'h0, 32'h0, 32'd7), 0, 0});
    for (int r = 0; r < dir_rows.size(); r++) begin
      send_item(dir_rows[r].it);
      if (dir_rows[r].has_exp && dir_rows[r].exp_elem0 !==
          pending_elems[pending_elems.size()-ELEMS].element_result)
        report_mismatch("directed row expectation");
    end
    drain_results();

    // Equal ticks give a zero fraction.
    send_item(make_item(OP_WR_TICK, 8'd1, 4'h0, 32'h0, 32'd100));
    send_item(make_item(OP_QUERY, 8'd0, 4'd0, 32'd0, 32'd5000));
    drain_results();

    // Random phases over several key counts, extremes included.
    for (int phase = 0; phase < 5; phase++) begin
      int n;
      int loaded;
      case (phase)
        0: n = 2;
        1: n = 256;
        2: n = 1;      // acts as two keys
        3: n = 511;    // acts as all keys
        default: n = 3;
      endcase
      write_key_count(n[CNT_W-1:0]);
      // The all-keys phases share a short table closed by a top tick, so the
      // search never walks past the written keys.
      case (phase)
        0: begin
          load_table(2, 1);
          loaded = 2;
        end
        1: begin
          load_table(3, 1);
          send_item(make_item(OP_WR_TICK, 8'd2, 4'd0, 32'd0, 32'hFFFF_FFFF));
          loaded = 3;
        end
        4: begin
          load_table(3, 0);
          loaded = 3;
        end
        default: loaded = (phase == 2) ? 2 : 3;
      endcase
      repeat ((phase == 0 || phase == 4) ? 10 : 8) begin
        t = tick_mem[$urandom_range(0, loaded-1)] + $urandom_range(0, 6000) - 1000;
        if ($urandom_range(0, 9) == 0) t = $urandom;
        if (n >= MAX_KEYS && t == 32'hFFFF_FFFF) t = 32'hFFFF_FFFE;
        case ($urandom_range(0, 9))
          0: send_item(make_item(OP_WR_ELEM, 8'($urandom_range(0, loaded-1)),
                                 4'($urandom), $urandom, $urandom));
          1: send_item(make_item(2'd3, 8'($urandom), 4'($urandom), $urandom, $urandom));
          default: send_item(make_item(OP_QUERY, 8'($urandom), 4'($urandom), $urandom, t));
        endcase
      end
      drain_results();
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/kmi_pkg.sv
sv/keyframe_matrix_interpolator.sv
sim/tb_top.sv
